### hw/rtl/wcsc_pkg.sv
// Shared types and constants for the world chunk split/compose block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package wcsc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 64;
    localparam int SIZE_W     = 32;
    localparam int NUM_AXES   = 3;
    localparam int DIV_STEPS  = COORD_W;
    localparam int DATA_W     = 2 * NUM_AXES * COORD_W;
    localparam int PROD_W     = COORD_W + SIZE_W + 2;

    localparam logic [SIZE_W-1:0] CHUNK_RESET = SIZE_W'(64'd32 << FRAC_BITS);

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SIZE_ZERO = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] idx;
        logic [COORD_W-1:0] res;
        logic               sat;
    } lane_out_t;

endpackage

### hw/rtl/wcsc_lane.sv
// One axis lane: bit-per-stage floored divider and a two-stage multiply-add.
// Depends on wcsc_pkg.
`timescale 1ns / 1ps
module wcsc_lane (
    input  logic                            aclk,
    input  logic                            en,
    input  logic                            act,
    input  logic [wcsc_pkg::COORD_W-1:0]    coord,
    input  logic [wcsc_pkg::COORD_W-1:0]    cell_idx,
    input  logic [wcsc_pkg::SIZE_W-1:0]     size,
    output wcsc_pkg::lane_out_t             lane_out
);
    import wcsc_pkg::*;

    logic [SIZE_W-1:0]  rem_reg  [0:DIV_STEPS];
    logic [COORD_W-1:0] quo_reg  [0:DIV_STEPS];
    logic               neg_reg  [0:DIV_STEPS];
    logic               act_reg  [0:DIV_STEPS];
    logic [COORD_W-1:0] cell_reg [0:DIV_STEPS];
    logic [COORD_W-1:0] comp_reg [2:DIV_STEPS];
    logic               csat_reg [2:DIV_STEPS];
    logic [COORD_W-1:0] loc0_reg;
    logic [COORD_W-1:0] loc1_reg;
    logic [COORD_W-1:0] p0_reg;
    logic [COORD_W-1:0] p1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= coord[COORD_W-1] ? -coord : coord;
            neg_reg[0]  <= coord[COORD_W-1];
            act_reg[0]  <= act;
            cell_reg[0] <= cell_idx;
            loc0_reg    <= coord;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] diff;
        logic            ge;
        assign trial = {rem_reg[k], quo_reg[k][COORD_W-1]};
        assign diff  = trial - {1'b0, size};
        assign ge    = trial >= {1'b0, size};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                quo_reg[k+1]  <= {quo_reg[k][COORD_W-2:0], ge};
                neg_reg[k+1]  <= neg_reg[k];
                act_reg[k+1]  <= act_reg[k];
                cell_reg[k+1] <= cell_reg[k];
            end
        end

        if (k == 0) begin : g_mul
            logic [COORD_W-1:0] mag;
            logic [COORD_W-1:0] p0_full;
            logic [COORD_W-1:0] p1_full;
            assign mag     = cell_reg[0][COORD_W-1] ? -cell_reg[0] : cell_reg[0];
            assign p0_full = mag[SIZE_W-1:0] * size;
            assign p1_full = mag[COORD_W-1:SIZE_W] * size;
            always_ff @(posedge aclk) begin
                if (en) begin
                    p0_reg   <= p0_full;
                    p1_reg   <= p1_full;
                    loc1_reg <= loc0_reg;
                end
            end
        end else if (k == 1) begin : g_add
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] sprod;
            logic [PROD_W-1:0] sum;
            logic              fit;
            assign prod  = {{(PROD_W-COORD_W){1'b0}}, p0_reg}
                         + {2'b00, p1_reg, {SIZE_W{1'b0}}};
            assign sprod = cell_reg[1][COORD_W-1] ? -prod : prod;
            assign sum   = sprod + {{(PROD_W-COORD_W){loc1_reg[COORD_W-1]}}, loc1_reg};
            assign fit   = (&sum[PROD_W-1:COORD_W-1]) || !(|sum[PROD_W-1:COORD_W-1]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    comp_reg[2] <= fit ? sum[COORD_W-1:0]
                                 : (sum[PROD_W-1] ? SAT_MIN : SAT_MAX);
                    csat_reg[2] <= !fit;
                end
            end
        end else begin : g_hold
            always_ff @(posedge aclk) begin
                if (en) begin
                    comp_reg[k+1] <= comp_reg[k];
                    csat_reg[k+1] <= csat_reg[k];
                end
            end
        end
    end

    logic [COORD_W-1:0] q_fin;
    logic [SIZE_W-1:0]  r_fin;
    assign q_fin = quo_reg[DIV_STEPS];
    assign r_fin = rem_reg[DIV_STEPS];

    always_comb begin
        lane_out.sat = 1'b0;
        if (act_reg[DIV_STEPS]) begin
            lane_out.idx = cell_reg[DIV_STEPS];
            lane_out.res = comp_reg[DIV_STEPS];
            lane_out.sat = csat_reg[DIV_STEPS];
        end else if (!neg_reg[DIV_STEPS]) begin
            lane_out.idx = q_fin;
            lane_out.res = {{(COORD_W-SIZE_W){1'b0}}, r_fin};
        end else if (r_fin == '0) begin
            lane_out.idx = -q_fin;
            lane_out.res = '0;
        end else begin
            lane_out.idx = ~q_fin;
            lane_out.res = {{(COORD_W-SIZE_W){1'b0}}, size - r_fin};
        end
    end

endmodule

### hw/rtl/wcsc_merge.sv
// Merge of the three lane results into one output word and its status.
// Depends on wcsc_pkg.
`timescale 1ns / 1ps
module wcsc_merge (
    input  wcsc_pkg::lane_out_t             lanes [wcsc_pkg::NUM_AXES],
    input  logic                            size_zero,
    output logic [wcsc_pkg::DATA_W-1:0]     data,
    output wcsc_pkg::status_t               status
);
    import wcsc_pkg::*;

    always_comb begin
        data   = '0;
        status = STATUS_OK;
        if (size_zero) begin
            status = STATUS_SIZE_ZERO;
        end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
                data[a*COORD_W +: COORD_W]            = lanes[a].idx;
                data[(NUM_AXES+a)*COORD_W +: COORD_W] = lanes[a].res;
                if (lanes[a].sat) begin
                    status = STATUS_SATURATED;
                end
            end
        end
    end

endmodule

### hw/rtl/world_chunk_split_compose.sv
// Pipeline: input register, 64 divider steps, then the output register.
// Throughput: one word per cycle when not stalled; the 64-step divider pipeline sets depth.
// Stalls only when the output register holds a word, m_tready is low and the last stage is full.
// Reset (aresetn low, synchronous) clears all valid bits and sets
// chunk_size to 32 m; no clearing pass. Depends on wcsc_pkg, wcsc_lane, wcsc_merge.
`timescale 1ns / 1ps
module world_chunk_split_compose (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [wcsc_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // coord_x, coord_y, coord_z, cell_x, cell_y, cell_z
    input  logic [wcsc_pkg::DATA_W-1:0]   s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // index_x, index_y, index_z, result_x, result_y, result_z
    output logic [wcsc_pkg::DATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                    m_tuser
);
    import wcsc_pkg::*;

    logic [SIZE_W-1:0] chunk_size_reg;
    logic              vld_reg [0:DIV_STEPS];
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    status_t           m_tuser_reg;
    logic              en;
    lane_out_t         lanes [NUM_AXES];
    logic [DATA_W-1:0] mrg_data;
    status_t           mrg_status;

    assign en       = !vld_reg[DIV_STEPS] || !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_RESET;
        end else if (cfg_wen) begin
            chunk_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DIV_STEPS; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= DIV_STEPS; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        wcsc_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .act      (s_tuser),
            .coord    (s_tdata[a*COORD_W +: COORD_W]),
            .cell_idx (s_tdata[(NUM_AXES+a)*COORD_W +: COORD_W]),
            .size     (chunk_size_reg),
            .lane_out (lanes[a])
        );
    end

    wcsc_merge u_merge (
        .lanes     (lanes),
        .size_zero (chunk_size_reg == '0),
        .data      (mrg_data),
        .status    (mrg_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && vld_reg[DIV_STEPS]) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[DIV_STEPS]) begin
            m_tdata_reg <= mrg_data;
            m_tuser_reg <= mrg_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### hw/rtl/wcsc_checker.sv
// Port-level checks for world_chunk_split_compose, bound to the top level.
// Depends on wcsc_pkg.
`timescale 1ns / 1ps
module wcsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wcsc_pkg::DATA_W-1:0]   m_tdata,
    input logic [1:0]                    m_tuser
);
    import wcsc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_SIZE_ZERO |-> m_tdata == '0)
        else $error("nonzero data with zero chunk size");

endmodule

bind world_chunk_split_compose wcsc_checker u_wcsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/chunk_checker.sv
// Checker for world_chunk_split_compose: watches both stream channels, predicts
// each result word from the accepted input word and the chunk size, and compares.
// Depends on wcsc_pkg; hands its failure count and outstanding depth to the top.
`timescale 1ns / 1ps
module chunk_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [wcsc_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [wcsc_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [wcsc_pkg::DATA_W-1:0] m_tdata,
    input  logic [1:0]                  m_tuser,
    output int                          fail_count,
    output int                          pending
);
    import wcsc_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] data;
        status_t           status;
    } conv_word_t;

    logic [SIZE_W-1:0] size_q;
    conv_word_t        expected_words[$];

    function automatic void split_lane(input logic signed [63:0] c, input logic [31:0] s,
                                       output logic [63:0] idx, output logic [63:0] loc);
        logic signed [127:0] cw;
        logic signed [127:0] sw;
        logic signed [127:0] q;
        logic signed [127:0] r;
        cw = c;
        sw = {96'd0, s};
        q = cw / sw;
        r = cw - q * sw;
        if (r < 0) begin
            q = q - 1;
            r = r + sw;
        end
        idx = q[63:0];
        loc = r[63:0];
    endfunction

    function automatic logic compose_lane(input logic signed [63:0] cell_idx,
                                          input logic signed [63:0] off,
                                          input logic [31:0] s, output logic [63:0] w);
        logic signed [127:0] full;
        full = 128'(cell_idx) * $signed({96'd0, s}) + 128'(off);
        if (full > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            w = SAT_MAX;
            return 1'b1;
        end
        if (full < -128'sh8000_0000_0000_0000) begin
            w = SAT_MIN;
            return 1'b1;
        end
        w = full[63:0];
        return 1'b0;
    endfunction

    function automatic conv_word_t predict_word(input logic [DATA_W-1:0] d, input logic act,
                                                input logic [31:0] s);
        conv_word_t o;
        logic [63:0] idx;
        logic [63:0] res;
        logic        sat;
        o.data = '0;
        o.status = STATUS_OK;
        if (s == 0) begin
            o.status = STATUS_SIZE_ZERO;
            return o;
        end
        sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!act) begin
                split_lane(d[64*a +: 64], s, idx, res);
            end else begin
                idx = d[64*(a+3) +: 64];
                if (compose_lane(idx, d[64*a +: 64], s, res)) sat = 1'b1;
            end
            o.data[64*a +: 64] = idx;
            o.data[64*(a+3) +: 64] = res;
        end
        if (sat) o.status = STATUS_SATURATED;
        return o;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        conv_word_t e;
        if (!aresetn) begin
            size_q <= CHUNK_RESET;
        end else begin
            if (cfg_wen) size_q <= cfg_wdata;
            if (s_tvalid && s_tready)
                expected_words.push_back(predict_word(s_tdata, s_tuser, size_q));
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word data=%h status=%0d", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (e.data[64*f +: 64] !== m_tdata[64*f +: 64]) begin
                            $error("%s: expected %h actual %h",
                                   f < 3 ? $sformatf("index_%0d", f)
                                         : $sformatf("result_%0d", f - 3),
                                   e.data[64*f +: 64], m_tdata[64*f +: 64]);
                            fail_count++;
                        end
                    end
                    if (e.status !== m_tuser) begin
                        $error("status: expected %0d actual %0d", e.status, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_words.size();
    end
endmodule

### bench/testbench.sv
// Stimulus and verdict for world_chunk_split_compose: directed extremes, then
// random split/compose words under three idling profiles and several chunk sizes.
// Depends on wcsc_pkg, the block's RTL and chunk_checker.
`timescale 1ns / 1ps
module testbench;
    import wcsc_pkg::*;

    localparam int LATENCY = 66;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    int                fail_count;
    int                pending;
    int                send_idle = 0;
    int                recv_idle = 0;

    always #5 aclk = ~aclk;

    world_chunk_split_compose dut (.*);

    chunk_checker checker_i (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [63:0] pick_coord();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'(signed'($urandom_range(200)) - 100);
            3: return {$urandom, $urandom};
            4: return 64'(signed'($urandom_range(1 << 24)) - (1 << 23)) << 16;
            5: return {{32{1'($urandom_range(1))}}, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic act, input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [DATA_W-1:0] d;
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < 6; a++) d[64*a +: 64] = pick_coord();
            send_word($urandom_range(1), d);
        end
    endtask

    task automatic drain_and_write(input logic [SIZE_W-1:0] s);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        logic [63:0] ext[4];
        ext = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0,
                64'hFFFF_FFFF_FFFF_FFFF};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle = 32;
        recv_idle = 73;
        for (int k = 0; k < 4; k++) begin
            send_word(1'b0, {6{ext[k]}});
            send_word(1'b1, {{3{ext[k]}}, {3{ext[3-k]}}});
        end
        send_word(1'b0, {64'd0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFE0_0000, 64'h20_0000, 64'd5});
        drain_and_write(32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) send_word(k[0], {6{ext[k]}});
        send_word(1'b1, {64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000, 64'd1,
                         64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd7});
        drain_and_write(32'd0);
        send_word(1'b0, {6{ext[1]}});
        send_word(1'b1, {6{ext[0]}});
        drain_and_write(32'd1);
        send_word(1'b0, {6{ext[0]}});
        send_word(1'b1, {6{ext[1]}});
        send_random(300);
        drain_and_write(32'h0001_8000);
        send_idle = 73;
        recv_idle = 32;
        send_random(350);
        drain_and_write($urandom);
        send_random(150);
        drain_and_write(32'h8000_0000);
        send_idle = 0;
        recv_idle = 0;
        send_random(150);
        drain_and_write(32'd0);
        send_random(20);
        drain_and_write(CHUNK_RESET);
        send_random(150);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
